FILE: sv/cau_pkg.sv
package cau_pkg;

    // Fixed-point format and internal widths
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;             // operand / result part
    localparam int PW        = 64;             // product width
    localparam int SW        = PW + 1;         // sum of two products
    localparam int QB        = 33;             // quotient bits kept (2^33 and up is huge)
    localparam int NW        = PW + FRAC_BITS; // scaled dividend

    localparam logic [DW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] SAT_NEG = 32'h8000_0000;

    // Operation codes
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_NEG = 3'd4;
    localparam logic [2:0] FN_EQ  = 3'd5;
    localparam logic [2:0] FN_NE  = 3'd6;

    typedef struct packed {
        logic [2:0]             func;
        logic signed [DW-1:0]   a_re;
        logic signed [DW-1:0]   a_im;
        logic signed [DW-1:0]   b_re;
        logic signed [DW-1:0]   b_im;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0]   res_re;
        logic signed [DW-1:0]   res_im;
        logic                   compare_true;
        logic                   overflow;
        logic                   divide_by_zero;
    } t_out;

    // After the multipliers
    typedef struct packed {
        logic [2:0]             func;
        logic signed [PW-1:0]   p_rr;
        logic signed [PW-1:0]   p_ii;
        logic signed [PW-1:0]   p_ri;
        logic signed [PW-1:0]   p_ir;
        logic [PW-1:0]          d_rr;
        logic [PW-1:0]          d_ii;
        t_out                   simple;
    } t_s1;

    // After the product sums
    typedef struct packed {
        logic [2:0]             func;
        logic signed [SW-1:0]   s_re;
        logic signed [SW-1:0]   s_im;
        logic [PW-1:0]          den;
        t_out                   simple;
    } t_s2;

    // One quotient lane of the divider
    typedef struct packed {
        logic                   neg;
        logic                   huge;
        logic [PW-1:0]          rem;
        logic [QB-1:0]          nlo;
        logic [QB-1:0]          q;
    } t_lane;

    // Word travelling through the divider steps
    typedef struct packed {
        logic [2:0]             func;
        logic [PW-1:0]          den;
        logic                   dz;
        t_lane                  re;
        t_lane                  im;
        t_out                   res;
    } t_dv;

    typedef struct packed {
        logic                   ovf;
        logic [DW-1:0]          val;
    } t_sat;

    // Clamp a 33-bit sum to 32 bits
    function automatic t_sat sat33(logic signed [DW:0] v);
        t_sat r;
        r.ovf = v[DW] != v[DW-1];
        r.val = r.ovf ? (v[DW] ? SAT_NEG : SAT_POS) : v[DW-1:0];
        return r;
    endfunction

    // Clamp a 65-bit value to 32 bits
    function automatic t_sat sat65(logic signed [SW-1:0] v);
        t_sat r;
        r.ovf = !((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1]));
        r.val = r.ovf ? (v[SW-1] ? SAT_NEG : SAT_POS) : v[DW-1:0];
        return r;
    endfunction

    // Clamp a sign/magnitude quotient to 32 bits
    function automatic t_sat satq(logic neg, logic huge, logic [QB-1:0] q);
        t_sat r;
        if (!neg) begin
            r.ovf = huge || (|q[QB-1:DW-1]);
            r.val = r.ovf ? SAT_POS : q[DW-1:0];
        end else begin
            r.ovf = huge || (q > QB'({1'b1, {(DW-1){1'b0}}}));
            r.val = r.ovf ? SAT_NEG : DW'(~q[DW-1:0] + DW'(1));
        end
        return r;
    endfunction

endpackage

FILE: sv/cau_prod.sv
module cau_prod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  cau_pkg::t_in    i_data,
    output logic            o_valid,
    output cau_pkg::t_s1    o_data
);

    logic           r_valid;
    cau_pkg::t_s1   r_data;
    cau_pkg::t_s1   n_data;

    // Six products, plus the results that need no multiplier
    always_comb begin
        cau_pkg::t_sat              sr;
        cau_pkg::t_sat              si;
        logic                       eq;
        sr = '0;
        si = '0;
        eq = (i_data.a_re == i_data.b_re) && (i_data.a_im == i_data.b_im);
        n_data.func = i_data.func;
        n_data.p_rr = cau_pkg::PW'(i_data.a_re) * cau_pkg::PW'(i_data.b_re);
        n_data.p_ii = cau_pkg::PW'(i_data.a_im) * cau_pkg::PW'(i_data.b_im);
        n_data.p_ri = cau_pkg::PW'(i_data.a_re) * cau_pkg::PW'(i_data.b_im);
        n_data.p_ir = cau_pkg::PW'(i_data.a_im) * cau_pkg::PW'(i_data.b_re);
        n_data.d_rr = cau_pkg::PW'(i_data.b_re) * cau_pkg::PW'(i_data.b_re);
        n_data.d_ii = cau_pkg::PW'(i_data.b_im) * cau_pkg::PW'(i_data.b_im);
        n_data.simple = '0;
        case (i_data.func)
            cau_pkg::FN_ADD: begin
                sr = cau_pkg::sat33(33'(i_data.a_re) + 33'(i_data.b_re));
                si = cau_pkg::sat33(33'(i_data.a_im) + 33'(i_data.b_im));
            end
            cau_pkg::FN_SUB: begin
                sr = cau_pkg::sat33(33'(i_data.a_re) - 33'(i_data.b_re));
                si = cau_pkg::sat33(33'(i_data.a_im) - 33'(i_data.b_im));
            end
            cau_pkg::FN_NEG: begin
                sr = cau_pkg::sat33(33'sd0 - 33'(i_data.a_re));
                si = cau_pkg::sat33(33'sd0 - 33'(i_data.a_im));
            end
            cau_pkg::FN_EQ:  n_data.simple.compare_true = eq;
            cau_pkg::FN_NE:  n_data.simple.compare_true = !eq;
            default: ;
        endcase
        n_data.simple.res_re   = sr.val;
        n_data.simple.res_im   = si.val;
        n_data.simple.overflow = sr.ovf | si.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/cau_sum.sv
module cau_sum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  cau_pkg::t_s1    i_data,
    output logic            o_valid,
    output cau_pkg::t_s2    o_data
);

    logic           r_valid;
    cau_pkg::t_s2   r_data;
    cau_pkg::t_s2   n_data;

    // Sum the cross products for either a product or a quotient numerator
    always_comb begin
        logic signed [cau_pkg::SW-1:0] rr;
        logic signed [cau_pkg::SW-1:0] ii;
        logic signed [cau_pkg::SW-1:0] ri;
        logic signed [cau_pkg::SW-1:0] ir;
        rr = cau_pkg::SW'(i_data.p_rr);
        ii = cau_pkg::SW'(i_data.p_ii);
        ri = cau_pkg::SW'(i_data.p_ri);
        ir = cau_pkg::SW'(i_data.p_ir);
        n_data.func   = i_data.func;
        n_data.simple = i_data.simple;
        n_data.den    = i_data.d_rr + i_data.d_ii;
        if (i_data.func == cau_pkg::FN_DIV) begin
            n_data.s_re = rr + ii;
            n_data.s_im = ir - ri;
        end else begin
            n_data.s_re = rr - ii;
            n_data.s_im = ri + ir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/cau_prep.sv
module cau_prep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  cau_pkg::t_s2    i_data,
    output logic            o_valid,
    output cau_pkg::t_dv    o_data
);

    logic           r_valid;
    cau_pkg::t_dv   r_data;
    cau_pkg::t_dv   n_data;

    // Sign/magnitude split of a numerator and the first quotient check
    function automatic cau_pkg::t_lane lane_init(logic signed [cau_pkg::SW-1:0] s,
                                                 logic [cau_pkg::PW-1:0] den);
        cau_pkg::t_lane             l;
        logic [cau_pkg::PW-1:0]     m;
        logic [cau_pkg::NW-1:0]     n;
        logic [cau_pkg::PW-1:0]     r0;
        l.neg = s[cau_pkg::SW-1];
        m     = l.neg ? cau_pkg::PW'(-s) : cau_pkg::PW'(s);
        n     = {m, {cau_pkg::FRAC_BITS{1'b0}}};
        r0    = cau_pkg::PW'(n[cau_pkg::NW-1:cau_pkg::QB]);
        l.huge = r0 >= den;
        l.rem  = r0;
        l.nlo  = n[cau_pkg::QB-1:0];
        l.q    = '0;
        return l;
    endfunction

    // Products finish here; quotients are set up for the divider
    always_comb begin
        cau_pkg::t_sat sr;
        cau_pkg::t_sat si;
        sr = cau_pkg::sat65(i_data.s_re >>> cau_pkg::FRAC_BITS);
        si = cau_pkg::sat65(i_data.s_im >>> cau_pkg::FRAC_BITS);
        n_data.func = i_data.func;
        n_data.den  = i_data.den;
        n_data.dz   = i_data.den == '0;
        n_data.re   = lane_init(i_data.s_re, i_data.den);
        n_data.im   = lane_init(i_data.s_im, i_data.den);
        n_data.res  = i_data.simple;
        if (i_data.func == cau_pkg::FN_MUL) begin
            n_data.res.res_re   = sr.val;
            n_data.res.res_im   = si.val;
            n_data.res.overflow = sr.ovf | si.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/cau_div_step.sv
module cau_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  cau_pkg::t_dv    i_data,
    output logic            o_valid,
    output cau_pkg::t_dv    o_data
);

    logic           r_valid;
    cau_pkg::t_dv   r_data;
    cau_pkg::t_dv   n_data;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic cau_pkg::t_lane lane_step(cau_pkg::t_lane l,
                                                 logic [cau_pkg::PW-1:0] den);
        cau_pkg::t_lane             o;
        logic [cau_pkg::PW:0]       sh;
        logic                       fit;
        sh    = {l.rem, l.nlo[cau_pkg::QB-1]};
        fit   = sh >= {1'b0, den};
        o     = l;
        o.nlo = {l.nlo[cau_pkg::QB-2:0], 1'b0};
        o.rem = fit ? cau_pkg::PW'(sh - {1'b0, den}) : sh[cau_pkg::PW-1:0];
        o.q   = {l.q[cau_pkg::QB-2:0], fit};
        return o;
    endfunction

    always_comb begin
        n_data    = i_data;
        n_data.re = lane_step(i_data.re, i_data.den);
        n_data.im = lane_step(i_data.im, i_data.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/cau_final.sv
module cau_final (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  cau_pkg::t_dv    i_data,
    output logic            o_valid,
    output cau_pkg::t_out   o_data
);

    logic           r_valid;
    cau_pkg::t_out  r_data;
    cau_pkg::t_out  n_data;

    // Quotient saturation and the zero-divisor case; output register
    always_comb begin
        cau_pkg::t_sat sr;
        cau_pkg::t_sat si;
        sr = cau_pkg::satq(i_data.re.neg, i_data.re.huge, i_data.re.q);
        si = cau_pkg::satq(i_data.im.neg, i_data.im.huge, i_data.im.q);
        n_data = i_data.res;
        if (i_data.func == cau_pkg::FN_DIV) begin
            if (i_data.dz) begin
                n_data = '0;
                n_data.divide_by_zero = 1'b1;
            end else begin
                n_data.res_re   = sr.val;
                n_data.res_im   = si.val;
                n_data.overflow = sr.ovf | si.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: sv/complex_arith_unit.sv
// Channel   Direction  Handshake            Word
// op        in         i_valid / o_stall    i_op  (cau_pkg::t_in)
// result    out        o_valid / i_stall    o_res (cau_pkg::t_out)
//
// One word accepted per cycle while o_stall is low; each taken word passes
// three stages for products, sums and set-up, 33 divider steps (one quotient
// bit each, both parts in parallel), and the output register.
// Reset (synchronous, active low) clears every stage's valid bit.
// The whole pipeline holds while a result waits under i_stall.
module complex_arith_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cau_pkg::t_in    i_op,
    output logic            o_valid,
    input  logic            i_stall,
    output cau_pkg::t_out   o_res
);

    logic           adv;
    logic           v1;
    logic           v2;
    logic           v3;
    cau_pkg::t_s1   d1;
    cau_pkg::t_s2   d2;
    cau_pkg::t_dv   d3;
    logic           dv_valid [0:cau_pkg::QB];
    cau_pkg::t_dv   dv_data  [0:cau_pkg::QB];

    // Pipeline moves unless a finished word is held at the output
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    cau_prod u_prod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(i_valid), .i_data(i_op), .o_valid(v1), .o_data(d1)
    );

    cau_sum u_sum (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(v1), .i_data(d1), .o_valid(v2), .o_data(d2)
    );

    cau_prep u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(v2), .i_data(d2), .o_valid(v3), .o_data(d3)
    );

    assign dv_valid[0] = v3;
    assign dv_data[0]  = d3;

    // Divider chain, one quotient bit per stage
    for (genvar g = 0; g < cau_pkg::QB; g++) begin : g_div
        cau_div_step u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
            .i_valid(dv_valid[g]), .i_data(dv_data[g]),
            .o_valid(dv_valid[g+1]), .o_data(dv_data[g+1])
        );
    end

    cau_final u_final (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv),
        .i_valid(dv_valid[cau_pkg::QB]), .i_data(dv_data[cau_pkg::QB]),
        .o_valid(o_valid), .o_data(o_res)
    );

    // Checks
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.divide_by_zero |->
            o_res.res_re == '0 && o_res.res_im == '0 && !o_res.overflow)
        else $error("divide by zero result not cleared");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.compare_true |->
            o_res.res_re == '0 && o_res.res_im == '0 && !o_res.overflow
            && !o_res.divide_by_zero)
        else $error("compare result carries arithmetic fields");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(dv_data[cau_pkg::QB]) || !$past(dv_valid[cau_pkg::QB]))
        else $error("divider stage moved during a stall");

endmodule

FILE: verif/complex_arith_unit_tb.sv
module complex_arith_unit_tb;

    localparam int LATENCY   = 37;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1025;
    localparam logic [2:0] FN_UNUSED = 3'd7;   // opcode with no operation

    // Exact predictor of one result word
    function automatic cau_pkg::t_out cplx_predict(cau_pkg::t_in op);
        cau_pkg::t_out r;
        logic signed [127:0] ar, ai, br, bi, s_re, s_im, den, q, v_re, v_im;
        logic eq;
        r = '0;
        ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
        eq = (op.a_re == op.b_re) && (op.a_im == op.b_im);
        v_re = 0; v_im = 0;
        case (op.func)
            cau_pkg::FN_ADD: begin v_re = ar + br; v_im = ai + bi; end
            cau_pkg::FN_SUB: begin v_re = ar - br; v_im = ai - bi; end
            cau_pkg::FN_MUL: begin
                // floor via arithmetic shift
                s_re = ar * br - ai * bi;
                s_im = ar * bi + ai * br;
                v_re = s_re >>> cau_pkg::FRAC_BITS;
                v_im = s_im >>> cau_pkg::FRAC_BITS;
            end
            cau_pkg::FN_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    // signed division truncates toward zero
                    s_re = (ar * br + ai * bi) <<< cau_pkg::FRAC_BITS;
                    s_im = (ai * br - ar * bi) <<< cau_pkg::FRAC_BITS;
                    v_re = s_re / den;
                    v_im = s_im / den;
                end
            end
            cau_pkg::FN_NEG: begin v_re = -ar; v_im = -ai; end
            cau_pkg::FN_EQ:  r.compare_true = eq;
            cau_pkg::FN_NE:  r.compare_true = !eq;
            default: ;
        endcase
        q = v_re;
        if (q > 128'sh7FFF_FFFF) begin
            r.res_re = cau_pkg::SAT_POS; r.overflow = 1'b1;
        end else if (q < -128'sh8000_0000) begin
            r.res_re = cau_pkg::SAT_NEG; r.overflow = 1'b1;
        end else r.res_re = q[31:0];
        q = v_im;
        if (q > 128'sh7FFF_FFFF) begin
            r.res_im = cau_pkg::SAT_POS; r.overflow = 1'b1;
        end else if (q < -128'sh8000_0000) begin
            r.res_im = cau_pkg::SAT_NEG; r.overflow = 1'b1;
        end else r.res_im = q[31:0];
        return r;
    endfunction

    class cplx_scoreboard;
        cau_pkg::t_out pending[$];
        int   n_bad;

        function void note_op(cau_pkg::t_in op);
            pending.push_back(cplx_predict(op));
        endfunction

        function void check_res(cau_pkg::t_out got);
            cau_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.res_re !== exp_r.res_re || got.res_im !== exp_r.res_im ||
                got.compare_true !== exp_r.compare_true ||
                got.overflow !== exp_r.overflow ||
                got.divide_by_zero !== exp_r.divide_by_zero) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("mismatch: re %h/%h im %h/%h cmp %b/%b ovf %b/%b dz %b/%b",
                        exp_r.res_re, got.res_re, exp_r.res_im, got.res_im,
                        exp_r.compare_true, got.compare_true,
                        exp_r.overflow, got.overflow,
                        exp_r.divide_by_zero, got.divide_by_zero);
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b1;
    logic  o_stall, o_valid;
    cau_pkg::t_in   i_op = '0;
    cau_pkg::t_out  o_res;

    cplx_scoreboard sb = new();
    int  idle_pct = 0;      // sender idle chance
    int  stall_pct = 0;     // receiver stall chance
    bit  hold_off = 1'b0;   // long receiver stall
    int  quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    complex_arith_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    // Sample both handshakes at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_op(i_op);
            if (o_valid && !i_stall) sb.check_res(o_res);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (quiet_cycles >= WDOG_MAX) begin
            $display("complex_arith_unit_tb NOT OK");
            $finish;
        end
    end

    // Receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b1;
        else i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    function automatic logic [31:0] rand_part();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4: return $signed($urandom_range(255) - 128) <<< 16;
            5: return $signed({{16{1'b0}}, 16'($urandom)}) - 32'sd32768;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and wait for its acceptance
    task automatic send_op(logic [2:0] fn, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
        cau_pkg::t_in op;
        op.func = fn; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        logic [2:0] fn;
        logic [31:0] ar, ai, br, bi;
        repeat (n) begin
            fn = 3'($urandom_range(7));
            ar = rand_part(); ai = rand_part(); br = rand_part(); bi = rand_part();
            if (fn == cau_pkg::FN_EQ || fn == cau_pkg::FN_NE) begin
                if ($urandom_range(1)) begin br = ar; bi = ai; end
                else if ($urandom_range(1)) br = ar;
            end
            if (fn == cau_pkg::FN_DIV && $urandom_range(7) == 0) begin br = 0; bi = 0; end
            if ($urandom_range(7) == 0) bi = 0;   // scalar operand
            send_op(fn, ar, ai, br, bi);
        end
    endtask

    // Long receiver hold-off while the sender keeps offering
    initial begin
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (120) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        int lim;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each operation, special cases
        send_op(cau_pkg::FN_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
        send_op(cau_pkg::FN_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0);
        send_op(cau_pkg::FN_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        send_op(cau_pkg::FN_SUB, 32'h0003_0000, 0, 32'h0001_0000, 32'h0002_0000);
        send_op(cau_pkg::FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
        send_op(cau_pkg::FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000);
        send_op(cau_pkg::FN_MUL, 32'hFFFF_FFFF, 0, 32'h1, 0);
        send_op(cau_pkg::FN_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                32'hFFFF_0000);
        send_op(cau_pkg::FN_DIV, 32'h0001_0000, 32'h0001_0000, 0, 0);
        send_op(cau_pkg::FN_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 0);
        send_op(cau_pkg::FN_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
        send_op(cau_pkg::FN_DIV, 32'h0001_0000, 0, 32'h0003_0000, 32'h0004_0000);
        send_op(cau_pkg::FN_DIV, 32'hFFFF_FFFF, 0, 32'h0003_0000, 0);
        send_op(cau_pkg::FN_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_op(cau_pkg::FN_NEG, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
        send_op(cau_pkg::FN_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678,
                32'h8000_0000);
        send_op(cau_pkg::FN_EQ, 32'h1234_5678, 32'h0, 32'h1234_5678, 32'h1);
        send_op(cau_pkg::FN_NE, 32'h1, 32'h2, 32'h1, 32'h2);
        send_op(cau_pkg::FN_NE, 32'h1, 32'h2, 32'h3, 32'h2);
        send_op(cau_pkg::FN_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_op(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases with varying idle/stall mixes
        idle_pct = 0;  stall_pct = 0;  send_random(N_RANDOM / 5);
        idle_pct = 49; stall_pct = 0;  send_random(N_RANDOM / 5);
        idle_pct = 0;  stall_pct = 49; send_random(N_RANDOM / 5);
        idle_pct = 37; stall_pct = 37; send_random(N_RANDOM / 5);
        idle_pct = 0;  stall_pct = 0;  send_random(N_RANDOM / 5);
        i_valid <= 1'b0;

        // Drain, then a short settle
        lim = 0;
        while (sb.pending.size() != 0 && lim < 200000) begin
            @(posedge i_clk);
            lim++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending.size() == 0)
            $display("complex_arith_unit_tb OK");
        else
            $display("complex_arith_unit_tb NOT OK");
        $finish;
    end

endmodule
